@@ src/enu_pkg.sv @@
// Shared constants and types for the ECEF to local east-up-north frame block.
// Used by every module under src; no dependencies of its own.
`default_nettype none

package enu_pkg;

    // Default coordinate and fraction widths.
    localparam int COORD_BITS = 40;
    localparam int FRAC_BITS  = 30;

    localparam int TOL_W    = 10;
    localparam int OUT_W    = 32;
    // The largest normalized magnitude lies in [2^29, 2^30).
    localparam int NORM_TOP = 30;
    // A normalized magnitude after the ellipsoid stretch of z fits in 31 bits.
    localparam int NM_W     = 31;
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = 32;

    // round((a^2/b^2 - 1) * 2^30) for WGS84.
    localparam int          E2P_W     = 23;
    localparam logic [22:0] E2P_Q30   = 23'd7236480;
    localparam int          E2P_SHIFT = 30;

    localparam logic [1:0] FRAME_REGULAR = 2'd0;
    localparam logic [1:0] FRAME_ORIGIN  = 2'd1;
    localparam logic [1:0] FRAME_POLE    = 2'd2;

    typedef struct packed {
        logic       neg_x;
        logic       neg_y;
        logic       neg_z;
        logic       z_pos;
        logic [1:0] fcase;
    } enu_side_t;

endpackage

`default_nettype wire

@@ src/enu_front.sv @@
// Front end: magnitudes and case detection, normalization of the up and east
// vectors, ellipsoid stretch of z and the squared sums. Uses enu_pkg.
`default_nettype none

module enu_front #(
    parameter int COORD_BITS = enu_pkg::COORD_BITS
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    adv,
    input  logic                                    in_valid,
    input  logic signed [COORD_BITS-1:0]            in_x,
    input  logic signed [COORD_BITS-1:0]            in_y,
    input  logic signed [COORD_BITS-1:0]            in_z,
    input  logic [enu_pkg::TOL_W-1:0]               tol,
    output logic                                    out_valid,
    output logic [2:0][enu_pkg::NM_W-1:0]           up_m,
    output logic [1:0][enu_pkg::NM_W-1:0]           east_m,
    output logic [1:0][enu_pkg::SQ_W-1:0]           rad,
    output enu_pkg::enu_side_t                      side
);

    localparam int NT     = enu_pkg::NORM_TOP;
    localparam int NM_W   = enu_pkg::NM_W;
    localparam int SQ_W   = enu_pkg::SQ_W;
    localparam int LEN_W  = $clog2(COORD_BITS + 1);
    localparam int WIDE_W = COORD_BITS + NT;
    localparam int ZP_W   = NT + enu_pkg::E2P_W;

    function automatic logic [LEN_W-1:0] bit_len(input logic [COORD_BITS-1:0] m);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            if (m[i]) begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    // m * 2^NT / 2^len: a left shift when len is small, a truncating right shift otherwise.
    function automatic logic [NT-1:0] norm(input logic [COORD_BITS-1:0] m,
                                           input logic [LEN_W-1:0] len);
        logic [WIDE_W-1:0] w;
        w = {m, {NT{1'b0}}} >> len;
        return w[NT-1:0];
    endfunction

    logic [5:0] valid_reg;

    logic [2:0][COORD_BITS-1:0] mag1_reg, mag1_next;
    enu_pkg::enu_side_t         side1_reg, side1_next;

    logic [2:0][COORD_BITS-1:0] mag2_reg;
    logic [COORD_BITS-1:0]      umax2_reg, umax2_next, emax2_reg, emax2_next;
    enu_pkg::enu_side_t         side2_reg;

    // Lanes: 0 x, 1 y, 2 z of up; 3 east x (from |y|), 4 east y (from |x|).
    logic [4:0][NT-1:0]         n3_reg, n3_next;
    enu_pkg::enu_side_t         side3_reg;

    logic [4:0][NT-1:0]         n4_reg;
    logic [ZP_W-1:0]            zp4_reg, zp4_next;
    logic [3:0][2*NT-1:0]       sq4_reg, sq4_next;
    enu_pkg::enu_side_t         side4_reg;

    logic [4:0][NT-1:0]         n5_reg;
    logic [NM_W-1:0]            uzs5_reg, uzs5_next;
    logic [3:0][2*NT-1:0]       sq5_reg;
    logic [2*NM_W-1:0]          sqz5_reg, sqz5_next;
    enu_pkg::enu_side_t         side5_reg;

    logic [1:0][SQ_W-1:0]       rad6_reg, rad6_next;
    logic [2:0][NM_W-1:0]       up6_reg, up6_next;
    logic [1:0][NM_W-1:0]       east6_reg, east6_next;
    enu_pkg::enu_side_t         side6_reg;

    logic [COORD_BITS-1:0]      tol_ext;
    logic                       sm_x, sm_y, sm_z;
    logic [LEN_W-1:0]           ulen, elen;

    always_comb begin
        mag1_next[0] = in_x[COORD_BITS-1] ? COORD_BITS'(-in_x) : COORD_BITS'(in_x);
        mag1_next[1] = in_y[COORD_BITS-1] ? COORD_BITS'(-in_y) : COORD_BITS'(in_y);
        mag1_next[2] = in_z[COORD_BITS-1] ? COORD_BITS'(-in_z) : COORD_BITS'(in_z);
        tol_ext = COORD_BITS'(tol);
        sm_x = mag1_next[0] <= tol_ext;
        sm_y = mag1_next[1] <= tol_ext;
        sm_z = mag1_next[2] <= tol_ext;
        side1_next.neg_x = in_x[COORD_BITS-1];
        side1_next.neg_y = in_y[COORD_BITS-1];
        side1_next.neg_z = in_z[COORD_BITS-1];
        side1_next.z_pos = !in_z[COORD_BITS-1] && (mag1_next[2] != '0);
        if (sm_x && sm_y && sm_z) begin
            side1_next.fcase = enu_pkg::FRAME_ORIGIN;
        end else if (sm_x && sm_y) begin
            side1_next.fcase = enu_pkg::FRAME_POLE;
        end else begin
            side1_next.fcase = enu_pkg::FRAME_REGULAR;
        end
    end

    always_comb begin
        emax2_next = (mag1_reg[1] > mag1_reg[0]) ? mag1_reg[1] : mag1_reg[0];
        umax2_next = (mag1_reg[2] > emax2_next) ? mag1_reg[2] : emax2_next;
    end

    always_comb begin
        ulen = bit_len(umax2_reg);
        elen = bit_len(emax2_reg);
        n3_next[0] = norm(mag2_reg[0], ulen);
        n3_next[1] = norm(mag2_reg[1], ulen);
        n3_next[2] = norm(mag2_reg[2], ulen);
        n3_next[3] = norm(mag2_reg[1], elen);
        n3_next[4] = norm(mag2_reg[0], elen);
    end

    always_comb begin
        zp4_next   = ZP_W'(n3_reg[2]) * ZP_W'(enu_pkg::E2P_Q30);
        sq4_next[0] = (2*NT)'(n3_reg[0]) * (2*NT)'(n3_reg[0]);
        sq4_next[1] = (2*NT)'(n3_reg[1]) * (2*NT)'(n3_reg[1]);
        sq4_next[2] = (2*NT)'(n3_reg[3]) * (2*NT)'(n3_reg[3]);
        sq4_next[3] = (2*NT)'(n3_reg[4]) * (2*NT)'(n3_reg[4]);
    end

    always_comb begin
        uzs5_next = NM_W'(n4_reg[2]) + NM_W'(zp4_reg >> enu_pkg::E2P_SHIFT);
        sqz5_next = (2*NM_W)'(uzs5_next) * (2*NM_W)'(uzs5_next);
    end

    always_comb begin
        rad6_next[0]  = SQ_W'(sq5_reg[0]) + SQ_W'(sq5_reg[1]) + SQ_W'(sqz5_reg);
        rad6_next[1]  = SQ_W'(sq5_reg[2]) + SQ_W'(sq5_reg[3]);
        up6_next[0]   = NM_W'(n5_reg[0]);
        up6_next[1]   = NM_W'(n5_reg[1]);
        up6_next[2]   = uzs5_reg;
        east6_next[0] = NM_W'(n5_reg[3]);
        east6_next[1] = NM_W'(n5_reg[4]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag1_reg  <= mag1_next;
            side1_reg <= side1_next;
            mag2_reg  <= mag1_reg;
            umax2_reg <= umax2_next;
            emax2_reg <= emax2_next;
            side2_reg <= side1_reg;
            n3_reg    <= n3_next;
            side3_reg <= side2_reg;
            n4_reg    <= n3_reg;
            zp4_reg   <= zp4_next;
            sq4_reg   <= sq4_next;
            side4_reg <= side3_reg;
            n5_reg    <= n4_reg;
            uzs5_reg  <= uzs5_next;
            sq5_reg   <= sq4_reg;
            sqz5_reg  <= sqz5_next;
            side5_reg <= side4_reg;
            rad6_reg  <= rad6_next;
            up6_reg   <= up6_next;
            east6_reg <= east6_next;
            side6_reg <= side5_reg;
        end
    end

    assign out_valid = valid_reg[5];
    assign up_m      = up6_reg;
    assign east_m    = east6_reg;
    assign rad       = rad6_reg;
    assign side      = side6_reg;

endmodule

`default_nettype wire

@@ src/enu_isqrt.sv @@
// Pipelined integer square root over several lanes, a fixed number of
// digit steps per stage, with a side vector carried alongside. Uses enu_pkg.
`default_nettype none

module enu_isqrt #(
    parameter int LANES  = 2,
    parameter int SIDE_W = 1,
    parameter int STEPS  = 2
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic [LANES-1:0][enu_pkg::SQ_W-1:0]    rad,
    input  logic [SIDE_W-1:0]                      side_in,
    output logic                                   out_valid,
    output logic [LANES-1:0][enu_pkg::ROOT_W-1:0]  root,
    output logic [SIDE_W-1:0]                      side_out
);

    localparam int RAD_W  = enu_pkg::SQ_W;
    localparam int NSTEP  = RAD_W / 2;
    localparam int STAGES = (NSTEP + STEPS - 1) / STEPS;

    logic [STAGES-1:0]               valid_reg;
    logic [LANES-1:0][RAD_W-1:0]     s_reg [STAGES];
    logic [LANES-1:0][RAD_W-1:0]     r_reg [STAGES];
    logic [LANES-1:0][RAD_W-1:0]     s_next [STAGES];
    logic [LANES-1:0][RAD_W-1:0]     r_next [STAGES];
    logic [SIDE_W-1:0]               side_reg [STAGES];

    // Classic bit-pair square root: each step tries the next root bit.
    always_comb begin
        logic [RAD_W-1:0] s_w, r_w, b_w, t_w;
        for (int st = 0; st < STAGES; st++) begin
            for (int ln = 0; ln < LANES; ln++) begin
                if (st == 0) begin
                    s_w = rad[ln];
                    r_w = '0;
                end else begin
                    s_w = s_reg[st-1][ln];
                    r_w = r_reg[st-1][ln];
                end
                for (int j = 0; j < STEPS; j++) begin
                    if (st * STEPS + j < NSTEP) begin
                        b_w = RAD_W'(1) << (RAD_W - 2 - 2 * (st * STEPS + j));
                        t_w = r_w + b_w;
                        if (s_w >= t_w) begin
                            s_w = s_w - t_w;
                            r_w = (r_w >> 1) + b_w;
                        end else begin
                            r_w = r_w >> 1;
                        end
                    end
                end
                s_next[st][ln] = s_w;
                r_next[st][ln] = r_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int st = 0; st < STAGES; st++) begin
                s_reg[st] <= s_next[st];
                r_reg[st] <= r_next[st];
                side_reg[st] <= (st == 0) ? side_in : side_reg[st-1];
            end
        end
    end

    always_comb begin
        for (int ln = 0; ln < LANES; ln++) begin
            root[ln] = r_reg[STAGES-1][ln][enu_pkg::ROOT_W-1:0];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

@@ src/enu_div.sv @@
// Pipelined restoring divider over several lanes: (m << FRAC_BITS) + r/2
// divided by r, a fixed number of quotient bits per stage. Uses enu_pkg.
`default_nettype none

module enu_div #(
    parameter int LANES     = 5,
    parameter int SIDE_W    = 1,
    parameter int FRAC_BITS = enu_pkg::FRAC_BITS,
    parameter int STEPS     = 2
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   adv,
    input  logic                                   in_valid,
    input  logic [LANES-1:0][enu_pkg::NM_W-1:0]    num_m,
    input  logic [LANES-1:0][enu_pkg::ROOT_W-1:0]  den,
    input  logic [SIDE_W-1:0]                      side_in,
    output logic                                   out_valid,
    output logic [LANES-1:0][FRAC_BITS:0]          quo,
    output logic [SIDE_W-1:0]                      side_out
);

    localparam int QB     = FRAC_BITS + 1;
    localparam int RW     = enu_pkg::ROOT_W;
    localparam int NUM_W  = enu_pkg::NM_W + FRAC_BITS + 1;
    localparam int STAGES = (QB + STEPS - 1) / STEPS;

    logic [STAGES-1:0]           valid_reg;
    logic [LANES-1:0][RW-1:0]    rem_reg [STAGES];
    logic [LANES-1:0][RW-1:0]    den_reg [STAGES];
    logic [LANES-1:0][QB-1:0]    lo_reg [STAGES];
    logic [LANES-1:0][QB-1:0]    q_reg [STAGES];
    logic [LANES-1:0][RW-1:0]    rem_next [STAGES];
    logic [LANES-1:0][RW-1:0]    den_next [STAGES];
    logic [LANES-1:0][QB-1:0]    lo_next [STAGES];
    logic [LANES-1:0][QB-1:0]    q_next [STAGES];
    logic [SIDE_W-1:0]           side_reg [STAGES];

    // The quotient never exceeds 2^FRAC_BITS, so the bits of the numerator
    // above the low QB already form a remainder below the divisor.
    always_comb begin
        logic [NUM_W-1:0] num_w;
        logic [RW-1:0]    rem_w, d_w;
        logic [QB-1:0]    lo_w, q_w;
        logic [RW:0]      t_w;
        for (int st = 0; st < STAGES; st++) begin
            for (int ln = 0; ln < LANES; ln++) begin
                if (st == 0) begin
                    num_w = {num_m[ln], {FRAC_BITS{1'b0}}} + NUM_W'(den[ln] >> 1);
                    rem_w = RW'(num_w >> QB);
                    lo_w  = num_w[QB-1:0];
                    q_w   = '0;
                    d_w   = den[ln];
                end else begin
                    num_w = '0;
                    rem_w = rem_reg[st-1][ln];
                    lo_w  = lo_reg[st-1][ln];
                    q_w   = q_reg[st-1][ln];
                    d_w   = den_reg[st-1][ln];
                end
                for (int j = 0; j < STEPS; j++) begin
                    if (st * STEPS + j < QB) begin
                        t_w  = {rem_w, lo_w[QB-1]};
                        lo_w = lo_w << 1;
                        if (t_w >= {1'b0, d_w}) begin
                            t_w = t_w - {1'b0, d_w};
                            q_w = {q_w[QB-2:0], 1'b1};
                        end else begin
                            q_w = {q_w[QB-2:0], 1'b0};
                        end
                        rem_w = t_w[RW-1:0];
                    end
                end
                rem_next[st][ln] = rem_w;
                lo_next[st][ln]  = lo_w;
                q_next[st][ln]   = q_w;
                den_next[st][ln] = d_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int st = 0; st < STAGES; st++) begin
                rem_reg[st] <= rem_next[st];
                lo_reg[st]  <= lo_next[st];
                q_reg[st]   <= q_next[st];
                den_reg[st] <= den_next[st];
                side_reg[st] <= (st == 0) ? side_in : side_reg[st-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quo       = q_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

`default_nettype wire

@@ src/enu_frame_from_ecef.sv @@
// Top level: local east-up-north frame of a WGS84 ECEF position.
// Instantiates enu_front, enu_isqrt and enu_div; uses enu_pkg.
//
//   Channel   Ports                              Moves
//   input     s_valid, s_ready, s_origin_*       one ECEF position per request
//   result    m_valid, m_ready, m_east_*, ...    one frame per request
//   config    cfg_wr_en, cfg_wr_data             near-zero tolerance
//
// A request may enter every cycle unless a stall holds the pipeline. The pipeline
// is the front end, the 32-step square root at two steps per stage, the
// divider at two quotient bits per stage, then the cross product and the
// output register. All stages advance together when the output register is
// empty or being taken, so a stall holds every stage.
// Reset clears the valid bits and sets the tolerance to zero.
`default_nettype none

module enu_frame_from_ecef #(
    parameter int COORD_BITS = enu_pkg::COORD_BITS,
    parameter int FRAC_BITS  = enu_pkg::FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [enu_pkg::TOL_W-1:0]        cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [COORD_BITS-1:0]     s_origin_x,
    input  logic signed [COORD_BITS-1:0]     s_origin_y,
    input  logic signed [COORD_BITS-1:0]     s_origin_z,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [enu_pkg::OUT_W-1:0] m_east_x,
    output logic signed [enu_pkg::OUT_W-1:0] m_east_y,
    output logic signed [enu_pkg::OUT_W-1:0] m_east_z,
    output logic signed [enu_pkg::OUT_W-1:0] m_up_x,
    output logic signed [enu_pkg::OUT_W-1:0] m_up_y,
    output logic signed [enu_pkg::OUT_W-1:0] m_up_z,
    output logic signed [enu_pkg::OUT_W-1:0] m_north_x,
    output logic signed [enu_pkg::OUT_W-1:0] m_north_y,
    output logic signed [enu_pkg::OUT_W-1:0] m_north_z,
    output logic [1:0]                       m_frame_case
);

    localparam int OUT_W     = enu_pkg::OUT_W;
    localparam int NM_W      = enu_pkg::NM_W;
    localparam int PW        = 2 * OUT_W;
    localparam int SIDE_W    = $bits(enu_pkg::enu_side_t);
    localparam int SQ_SIDE_W = 5 * NM_W + SIDE_W;
    localparam logic signed [OUT_W-1:0] ONE     = OUT_W'(64'd1 << FRAC_BITS);
    localparam logic signed [OUT_W-1:0] NEG_ONE = -ONE;
    localparam logic [PW:0] HALF  = (PW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [PW:0] ONE_W = (PW + 1)'(1) << FRAC_BITS;

    // Round to nearest at FRAC_BITS, ties away from zero, clamped to one.
    function automatic logic signed [OUT_W-1:0] round_frac(input logic signed [PW:0] p);
        logic [PW:0] mag, rnd;
        mag = p[PW] ? (PW + 1)'(-p) : (PW + 1)'(p);
        rnd = (mag + HALF) >> FRAC_BITS;
        if (rnd > ONE_W) begin
            rnd = ONE_W;
        end
        return p[PW] ? -OUT_W'(rnd) : OUT_W'(rnd);
    endfunction

    logic [enu_pkg::TOL_W-1:0] tol_reg;
    logic                      adv;

    logic                              fr_valid;
    logic [2:0][NM_W-1:0]              fr_up_m, sq_up_m;
    logic [1:0][NM_W-1:0]              fr_east_m, sq_east_m;
    logic [1:0][enu_pkg::SQ_W-1:0]     fr_rad;
    enu_pkg::enu_side_t                fr_side, sq_side, dv_side;

    logic                              sq_valid;
    logic [1:0][enu_pkg::ROOT_W-1:0]   sq_root;
    logic [SQ_SIDE_W-1:0]              sqs_in, sqs_out;

    logic                              dv_valid;
    logic [4:0][NM_W-1:0]              dv_num;
    logic [4:0][enu_pkg::ROOT_W-1:0]   dv_den;
    logic [4:0][FRAC_BITS:0]           dv_quo;
    logic [SIDE_W-1:0]                 dv_side_vec;

    logic                              b1_valid_reg;
    logic signed [OUT_W-1:0]           u_reg [3];
    logic signed [OUT_W-1:0]           u_next [3];
    logic signed [OUT_W-1:0]           e_reg [2];
    logic signed [OUT_W-1:0]           e_next [2];
    logic signed [PW-1:0]              p_reg [4];
    logic signed [PW-1:0]              p_next [4];
    enu_pkg::enu_side_t                b1_side_reg;
    logic signed [OUT_W-1:0]           qv [5];

    logic                              m_valid_reg;
    logic signed [OUT_W-1:0]           east_x_reg, east_x_next, east_y_reg, east_y_next;
    logic signed [OUT_W-1:0]           up_x_reg, up_x_next, up_y_reg, up_y_next;
    logic signed [OUT_W-1:0]           up_z_reg, up_z_next;
    logic signed [OUT_W-1:0]           north_x_reg, north_x_next, north_y_reg, north_y_next;
    logic signed [OUT_W-1:0]           north_z_reg, north_z_next;
    logic [1:0]                        fcase_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    enu_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_valid),
        .in_x     (s_origin_x),
        .in_y     (s_origin_y),
        .in_z     (s_origin_z),
        .tol      (tol_reg),
        .out_valid(fr_valid),
        .up_m     (fr_up_m),
        .east_m   (fr_east_m),
        .rad      (fr_rad),
        .side     (fr_side)
    );

    assign sqs_in = {fr_up_m, fr_east_m, fr_side};

    enu_isqrt #(
        .LANES (2),
        .SIDE_W(SQ_SIDE_W),
        .STEPS (2)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (fr_valid),
        .rad      (fr_rad),
        .side_in  (sqs_in),
        .out_valid(sq_valid),
        .root     (sq_root),
        .side_out (sqs_out)
    );

    assign {sq_up_m, sq_east_m, sq_side} = sqs_out;

    // Lanes 0 to 2 are up over the up root; lanes 3 and 4 are east over the east root.
    assign dv_num = {sq_east_m[1], sq_east_m[0], sq_up_m[2], sq_up_m[1], sq_up_m[0]};
    assign dv_den = {sq_root[1], sq_root[1], sq_root[0], sq_root[0], sq_root[0]};

    enu_div #(
        .LANES    (5),
        .SIDE_W   (SIDE_W),
        .FRAC_BITS(FRAC_BITS),
        .STEPS    (2)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (sq_valid),
        .num_m    (dv_num),
        .den      (dv_den),
        .side_in  (sq_side),
        .out_valid(dv_valid),
        .quo      (dv_quo),
        .side_out (dv_side_vec)
    );

    assign dv_side = dv_side_vec;

    // Signs, the pole substitute for east, and the cross-product terms.
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            qv[i] = OUT_W'(dv_quo[i]);
        end
        u_next[0] = dv_side.neg_x ? -qv[0] : qv[0];
        u_next[1] = dv_side.neg_y ? -qv[1] : qv[1];
        u_next[2] = dv_side.neg_z ? -qv[2] : qv[2];
        if (dv_side.fcase == enu_pkg::FRAME_POLE) begin
            e_next[0] = dv_side.z_pos ? ONE : NEG_ONE;
            e_next[1] = '0;
        end else begin
            e_next[0] = dv_side.neg_y ? qv[3] : -qv[3];
            e_next[1] = dv_side.neg_x ? -qv[4] : qv[4];
        end
        p_next[0] = PW'(u_next[2]) * PW'(e_next[1]);
        p_next[1] = PW'(u_next[2]) * PW'(e_next[0]);
        p_next[2] = PW'(u_next[0]) * PW'(e_next[1]);
        p_next[3] = PW'(u_next[1]) * PW'(e_next[0]);
    end

    always_comb begin
        if (b1_side_reg.fcase == enu_pkg::FRAME_ORIGIN) begin
            east_x_next  = '0;
            east_y_next  = ONE;
            up_x_next    = NEG_ONE;
            up_y_next    = '0;
            up_z_next    = '0;
            north_x_next = '0;
            north_y_next = '0;
            north_z_next = ONE;
        end else begin
            east_x_next  = e_reg[0];
            east_y_next  = e_reg[1];
            up_x_next    = u_reg[0];
            up_y_next    = u_reg[1];
            up_z_next    = u_reg[2];
            north_x_next = round_frac(-{p_reg[0][PW-1], p_reg[0]});
            north_y_next = round_frac({p_reg[1][PW-1], p_reg[1]});
            north_z_next = round_frac({p_reg[2][PW-1], p_reg[2]} - {p_reg[3][PW-1], p_reg[3]});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            b1_valid_reg <= dv_valid;
            m_valid_reg  <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg       <= u_next;
            e_reg       <= e_next;
            p_reg       <= p_next;
            b1_side_reg <= dv_side;
            east_x_reg  <= east_x_next;
            east_y_reg  <= east_y_next;
            up_x_reg    <= up_x_next;
            up_y_reg    <= up_y_next;
            up_z_reg    <= up_z_next;
            north_x_reg <= north_x_next;
            north_y_reg <= north_y_next;
            north_z_reg <= north_z_next;
            fcase_reg   <= b1_side_reg.fcase;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_east_x     = east_x_reg;
    assign m_east_y     = east_y_reg;
    assign m_east_z     = '0;
    assign m_up_x       = up_x_reg;
    assign m_up_y       = up_y_reg;
    assign m_up_z       = up_z_reg;
    assign m_north_x    = north_x_reg;
    assign m_north_y    = north_y_reg;
    assign m_north_z    = north_z_reg;
    assign m_frame_case = fcase_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_pole_east: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_case == enu_pkg::FRAME_POLE |->
            m_east_y == '0 && (m_east_x == ONE || m_east_x == NEG_ONE))
        else $error("pole frame without a unit east along x");

    a_up_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_case == enu_pkg::FRAME_REGULAR |->
            m_up_x <= ONE && m_up_x >= NEG_ONE && m_up_y <= ONE && m_up_y >= NEG_ONE &&
            m_up_z <= ONE && m_up_z >= NEG_ONE)
        else $error("up component outside the unit range");

endmodule

`default_nettype wire

@@ tb/enu_frame_from_ecef_tb.sv @@
// Self-checking testbench for enu_frame_from_ecef: drives ECEF positions and
// compares each frame against a behavioral predictor. Depends on enu_pkg and the RTL.
`default_nettype none

module enu_frame_from_ecef_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 40;
    localparam int FB = 30;
    localparam longint ONE = 64'sd1 << FB;
    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] e [3];
        logic signed [31:0] u [3];
        logic signed [31:0] n [3];
        logic [1:0]         fc;
    } frame_t;

    typedef struct {
        logic signed [CW-1:0] x, y, z;
        bit                   known;
        frame_t               f;
    } stim_row_t;

    logic aclk = 0, aresetn = 0;
    logic cfg_wr_en = 0;
    logic [enu_pkg::TOL_W-1:0] cfg_wr_data = '0;
    logic s_valid = 0, s_ready;
    logic signed [CW-1:0] s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    logic m_valid, m_ready = 0;
    logic signed [enu_pkg::OUT_W-1:0] m_east_x, m_east_y, m_east_z, m_up_x, m_up_y, m_up_z;
    logic signed [enu_pkg::OUT_W-1:0] m_north_x, m_north_y, m_north_z;
    logic [1:0] m_frame_case;

    enu_frame_from_ecef dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_origin_x(s_origin_x),
        .s_origin_y(s_origin_y), .s_origin_z(s_origin_z), .m_valid(m_valid),
        .m_ready(m_ready), .m_east_x(m_east_x), .m_east_y(m_east_y),
        .m_east_z(m_east_z), .m_up_x(m_up_x), .m_up_y(m_up_y), .m_up_z(m_up_z),
        .m_north_x(m_north_x), .m_north_y(m_north_y), .m_north_z(m_north_z),
        .m_frame_case(m_frame_case)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    frame_t pending_frames [$];
    logic [9:0] tolerance = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0, recv_stall_pct = 0;
    bit hold_off = 0;

    function automatic longint unsigned isqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Scales three magnitudes so the largest lands in [2^29, 2^30), optionally
    // stretches z onto the ellipsoid, and divides by the rounded-down length.
    task automatic unit_vector(input longint unsigned m0, m1, m2, input bit stretch,
                               output longint unsigned q [3]);
        longint unsigned m [3];
        longint unsigned mx, s, r;
        int len;
        m = '{m0, m1, m2};
        q = '{0, 0, 0};
        mx = m0 > m1 ? m0 : m1;
        if (m2 > mx) mx = m2;
        if (mx == 0) return;
        len = 0;
        while (len < 64 && (mx >> len) != 0) len++;
        for (int i = 0; i < 3; i++)
            m[i] = len > 30 ? m[i] >> (len - 30) : m[i] << (30 - len);
        if (stretch) m[2] += (m[2] * 64'd7236480) >> 30;
        s = 0;
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        r = isqrt(s);
        if (r == 0) return;
        for (int i = 0; i < 3; i++) q[i] = ((m[i] << FB) + r / 2) / r;
    endtask

    function automatic longint round_q(longint p);
        longint unsigned m;
        m = p < 0 ? -p : p;
        m = (m + (64'd1 << (FB - 1))) >> FB;
        if (m > ONE) m = ONE;
        return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned magnitude(logic signed [CW-1:0] v);
        return v < 0 ? longint'(-longint'(v)) : longint'(v);
    endfunction

    // Case-equality compare so that unknown bits on the outputs count as a miss.
    function automatic bit frames_differ(frame_t a, frame_t b);
        bit d;
        d = a.fc !== b.fc;
        for (int i = 0; i < 3; i++)
            d = d || (a.e[i] !== b.e[i]) || (a.u[i] !== b.u[i]) || (a.n[i] !== b.n[i]);
        return d;
    endfunction

    task automatic predict_frame(input logic signed [CW-1:0] x, y, z, output frame_t f);
        longint unsigned ax, ay, az, q [3];
        longint e [3], u [3], n [3];
        ax = magnitude(x); ay = magnitude(y); az = magnitude(z);
        f.fc = enu_pkg::FRAME_REGULAR;
        if (ax <= tolerance && ay <= tolerance && az <= tolerance) begin
            e = '{0, ONE, 0}; u = '{-ONE, 0, 0}; n = '{0, 0, ONE};
            f.fc = enu_pkg::FRAME_ORIGIN;
        end else begin
            unit_vector(ax, ay, az, 1, q);
            u[0] = x < 0 ? -longint'(q[0]) : q[0];
            u[1] = y < 0 ? -longint'(q[1]) : q[1];
            u[2] = z < 0 ? -longint'(q[2]) : q[2];
            if (ax <= tolerance && ay <= tolerance) begin
                e[0] = z > 0 ? ONE : -ONE;
                e[1] = 0;
                f.fc = enu_pkg::FRAME_POLE;
            end else begin
                unit_vector(ay, ax, 0, 0, q);
                e[0] = y < 0 ? q[0] : -longint'(q[0]);
                e[1] = x < 0 ? -longint'(q[1]) : q[1];
            end
            e[2] = 0;
            n[0] = round_q(u[1] * e[2] - u[2] * e[1]);
            n[1] = round_q(u[2] * e[0] - u[0] * e[2]);
            n[2] = round_q(u[0] * e[1] - u[1] * e[0]);
        end
        for (int i = 0; i < 3; i++) begin
            f.e[i] = e[i][31:0]; f.u[i] = u[i][31:0]; f.n[i] = n[i][31:0];
        end
    endtask

    function automatic frame_t fixed_frame(longint e0, e1, u0, u1, u2, n0, n1, n2,
                                           logic [1:0] fc);
        frame_t f;
        f.e = '{e0[31:0], e1[31:0], 0};
        f.u = '{u0[31:0], u1[31:0], u2[31:0]};
        f.n = '{n0[31:0], n1[31:0], n2[31:0]};
        f.fc = fc;
        return f;
    endfunction

    // Result side: compare every accepted frame with the oldest expectation.
    always @(posedge aclk) begin
        frame_t exp_f, got;
        if (aresetn && m_valid && m_ready) begin
            got.e = '{m_east_x, m_east_y, m_east_z};
            got.u = '{m_up_x, m_up_y, m_up_z};
            got.n = '{m_north_x, m_north_y, m_north_z};
            got.fc = m_frame_case;
            if (pending_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
            end else begin
                exp_f = pending_frames.pop_front();
                if (frames_differ(got, exp_f)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at %0t: exp e=%p u=%p n=%p c=%0d got e=%p u=%p n=%p c=%0d",
                                 $realtime, exp_f.e, exp_f.u, exp_f.n, exp_f.fc,
                                 got.e, got.u, got.n, got.fc);
                end
            end
        end
        m_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles in which no request moves on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Valid stays high from one request to the next unless the sender idles.
    task automatic send_position(input logic signed [CW-1:0] x, y, z);
        frame_t f;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_origin_x <= x; s_origin_y <= y; s_origin_z <= z;
        predict_frame(x, y, z, f);
        do @(posedge aclk); while (!s_ready);
        pending_frames.push_back(f);
    endtask

    task automatic send_checked(input stim_row_t row);
        frame_t f;
        predict_frame(row.x, row.y, row.z, f);
        if (row.known && frames_differ(f, row.f)) begin
            mismatches++;
            if (mismatches <= 10) $display("Predictor disagrees with table row");
        end
        send_position(row.x, row.y, row.z);
    endtask

    task automatic drain_and_settle();
        s_valid <= 0;
        while (pending_frames.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_tolerance(input logic [9:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        tolerance = v;
    endtask

    function automatic logic signed [CW-1:0] random_coord(input int mode);
        logic signed [CW-1:0] v;
        v = CW'({$urandom, $urandom});
        case (mode)
            0: return v;
            1: return v >>> $urandom_range(38);
            2: return $signed(CW'($urandom_range(2047))) - 1024;
            default: return $urandom_range(1) ? {1'b1, {CW-1{1'b0}}} : {1'b0, {CW-1{1'b1}}};
        endcase
    endfunction

    localparam logic signed [CW-1:0] CMAX = {1'b0, {CW-1{1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {CW-1{1'b0}}};

    initial begin
        stim_row_t rows [$];
        frame_t org;
        logic [9:0] tol_set [5];
        int pct [4][2];
        logic signed [CW-1:0] rx, ry, rz;
        int mode;
        int wait_count;

        org = fixed_frame(0, ONE, -ONE, 0, 0, 0, 0, ONE, enu_pkg::FRAME_ORIGIN);
        // Directed rows: origin, poles, axes, extremes, near-tolerance values.
        rows = '{
            '{0, 0, 0, 1, org},
            '{0, 0, 1, 1, fixed_frame(ONE, 0, 0, 0, ONE, 0, ONE, 0, enu_pkg::FRAME_POLE)},
            '{0, 0, -1, 1, fixed_frame(-ONE, 0, 0, 0, -ONE, 0, ONE, 0, enu_pkg::FRAME_POLE)},
            '{1, 0, 0, 1, fixed_frame(0, ONE, ONE, 0, 0, 0, 0, ONE, enu_pkg::FRAME_REGULAR)},
            '{-1, 0, 0, 1, fixed_frame(0, -ONE, -ONE, 0, 0, 0, 0, ONE, enu_pkg::FRAME_REGULAR)},
            '{0, 1, 0, 1, fixed_frame(-ONE, 0, 0, ONE, 0, 0, 0, ONE, enu_pkg::FRAME_REGULAR)},
            '{0, -1, 0, 1, fixed_frame(ONE, 0, 0, -ONE, 0, 0, 0, ONE, enu_pkg::FRAME_REGULAR)},
            '{CMAX, CMAX, CMAX, 0, org}, '{CMIN, CMIN, CMIN, 0, org},
            '{CMAX, CMIN, 0, 0, org}, '{CMIN, CMAX, CMAX, 0, org},
            '{0, 0, CMAX, 0, org}, '{0, 0, CMIN, 0, org},
            '{CMIN, 0, 0, 0, org}, '{0, CMIN, 0, 0, org},
            '{-40'sd1, -40'sd1, -40'sd1, 0, org},
            '{40'sd6378137000, 0, 0, 0, org}, '{0, 40'sd6378137000, 40'sd1, 0, org},
            '{40'sd4510731000, 40'sd4510731000, 40'sd4487348000, 0, org},
            '{-40'sd3000, 40'sd5, -40'sd6356752314, 0, org}
        };
        tol_set = '{10'd0, 10'd1023, 10'd1, 10'd500, 10'd0};
        pct = '{'{0, 0}, '{71, 0}, '{0, 71}, '{17, 17}};

        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (rows[i]) send_checked(rows[i]);
        drain_and_settle();

        // Long receiver hold-off while the sender keeps offering positions.
        hold_off = 1;
        fork
            begin
                wait_count = 0;
                while (wait_count < 300) begin
                    @(posedge aclk);
                    wait_count++;
                end
                hold_off = 0;
            end
            for (int k = 0; k < 60; k++)
                send_position(random_coord(1), random_coord(1), random_coord(1));
        join
        drain_and_settle();

        for (int ph = 0; ph < 5; ph++) begin
            write_tolerance(tol_set[ph]);
            // Send tolerance-edge positions under the new setting.
            for (int k = 0; k < 4; k++) begin
                rx = $urandom_range(1) ? tol_set[ph] : -$signed({1'b0, tol_set[ph]}) - k % 2;
                send_position(rx, tol_set[ph] + (k / 2), k == 3 ? 0 : rx);
            end
            for (int st = 0; st < 4; st++) begin
                send_idle_pct = pct[st][0];
                recv_stall_pct = pct[st][1];
                for (int k = 0; k < 85; k++) begin
                    mode = $urandom_range(9);
                    if (mode < 5) mode = 0;
                    else if (mode < 8) mode = 1;
                    else if (mode < 9) mode = 2;
                    else mode = 3;
                    rx = random_coord(mode); ry = random_coord(mode); rz = random_coord(mode);
                    if ($urandom_range(9) == 0) begin
                        rx = random_coord(2); ry = random_coord(2);
                    end
                    send_position(rx, ry, rz);
                end
            end
            send_idle_pct = 0;
            recv_stall_pct = 0;
            // Sender waits here for every expected frame before the next setting.
            drain_and_settle();
        end

        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

`default_nettype wire
